### rtl/ets_pkg.sv
`timescale 1ns / 1ps

package ets_pkg;

    localparam int CURVE_POINTS = 17;
    localparam int TABLE_SLOTS  = 32;
    localparam int TBL_IDX_W    = $clog2(TABLE_SLOTS);

    localparam int TORQUE_W = 16;
    localparam int SPEED_W  = 16;
    localparam int FACTOR_W = 9;
    localparam int PEDAL_W  = 15;
    localparam int DRATE_W  = 11;
    localparam int GAIN_W   = 19;

    localparam logic [TORQUE_W-1:0]  TORQUE_MAX = 16'd56800;
    localparam logic signed [15:0]   ACCEL_LO   = 16'sd4506;
    localparam logic signed [15:0]   ACCEL_HI   = 16'sd5530;
    localparam logic [PEDAL_W-1:0]   PEDAL_FULL = 15'd25600;
    localparam logic [DRATE_W-1:0]   DRATE_SPAN = 11'd1024;
    localparam logic [FACTOR_W-1:0]  FACTOR_ONE = 9'd256;
    localparam logic [GAIN_W-1:0]    GAIN_ONE   = 19'd262144;

    // ceil(2^26 / 25): exact floor division by 25 for operands below 2^21
    localparam logic [21:0]          PED_RECIP  = 22'd2684355;

    localparam logic [15:0] ENGINE_SPEED_RST = 16'd16077;
    localparam logic [8:0]  DERATE_RST       = 9'd128;
    localparam logic [8:0]  FILTER_RST       = 9'd128;

    localparam int DIV_Q_W   = 16;
    localparam int DIV_DEN_W = 16;
    localparam int DIV_NUM_W = DIV_Q_W + DIV_DEN_W;
    localparam int DIV_CNT_W = $clog2(DIV_Q_W + 1);

    typedef logic [15:0] curve_tbl_t [TABLE_SLOTS];

    localparam curve_tbl_t CURVE_X = '{
        0: 16'd0,      1: 16'd16085,  2: 16'd18766,  3: 16'd21446,
        4: 16'd24127,  5: 16'd26808,  6: 16'd29489,  7: 16'd32170,
        8: 16'd34851,  9: 16'd37531, 10: 16'd40212, 11: 16'd42893,
       12: 16'd45574, 13: 16'd48255, 14: 16'd50936, 15: 16'd53616,
       16: 16'd56297, default: 16'd0
    };

    localparam curve_tbl_t CURVE_Y = '{
        0: 16'd0,      1: 16'd26560,  2: 16'd30080,  3: 16'd35840,
        4: 16'd46400,  5: 16'd56800,  6: 16'd56800,  7: 16'd56800,
        8: 16'd56800,  9: 16'd56800, 10: 16'd55520, 11: 16'd52960,
       12: 16'd49920, 13: 16'd46080, 14: 16'd42560, 15: 16'd26880,
       16: 16'd0, default: 16'd0
    };

    typedef enum logic [1:0] {
        REG_ENGINE_SPEED  = 2'd0,
        REG_DERATE_FACTOR = 2'd1,
        REG_FILTER_COEF   = 2'd2
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEG_MUL,
        ST_DIV_SEG,
        ST_WAIT_SEG,
        ST_MAXT,
        ST_PED_MUL,
        ST_DIV_PED,
        ST_RAW,
        ST_LIM,
        ST_DIFF,
        ST_DT_MUL,
        ST_FILT,
        ST_DONE
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SEG_MUL,
        OP_DIV_SEG,
        OP_MAXT,
        OP_PED_MUL,
        OP_DIV_PED,
        OP_RAW,
        OP_LIM,
        OP_DIFF,
        OP_DT_MUL,
        OP_FILT
    } op_t;

    typedef struct packed {
        op_t  op;
        logic out_load;
    } dp_cmd_t;

    typedef struct packed {
        logic div_done;
    } dp_status_t;

    typedef struct packed {
        logic [SPEED_W-1:0]  engine_speed;
        logic [FACTOR_W-1:0] derate_factor;
        logic [FACTOR_W-1:0] filter_coefficient;
    } cfg_t;

endpackage

### rtl/ets_div.sv
`timescale 1ns / 1ps

module ets_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [ets_pkg::DIV_NUM_W-1:0] dividend,
    input  logic [ets_pkg::DIV_DEN_W-1:0] divisor,
    output logic                          done,
    output logic [ets_pkg::DIV_Q_W-1:0]   quotient
);

    logic [ets_pkg::DIV_DEN_W-1:0] rem_reg;
    logic [ets_pkg::DIV_Q_W-1:0]   quo_reg;
    logic [ets_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                          done_reg;

    logic [ets_pkg::DIV_DEN_W:0]   trial;
    logic [ets_pkg::DIV_DEN_W:0]   trial_sub;
    logic                          fits;

    assign trial     = {rem_reg, quo_reg[ets_pkg::DIV_Q_W-1]};
    assign trial_sub = trial - {1'b0, divisor};
    assign fits      = (trial >= {1'b0, divisor});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else if (start) begin
            cnt_reg  <= ets_pkg::DIV_CNT_W'(ets_pkg::DIV_Q_W);
            done_reg <= 1'b0;
        end else if (cnt_reg != '0) begin
            cnt_reg  <= cnt_reg - 1'b1;
            done_reg <= (cnt_reg == ets_pkg::DIV_CNT_W'(1));
        end else begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend[ets_pkg::DIV_NUM_W-1:ets_pkg::DIV_Q_W];
            quo_reg <= dividend[ets_pkg::DIV_Q_W-1:0];
        end else if (cnt_reg != '0) begin
            rem_reg <= fits ? trial_sub[ets_pkg::DIV_DEN_W-1:0]
                            : trial[ets_pkg::DIV_DEN_W-1:0];
            quo_reg <= {quo_reg[ets_pkg::DIV_Q_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

### rtl/ets_datapath.sv
`timescale 1ns / 1ps

module ets_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ets_pkg::dp_cmd_t              cmd,
    input  ets_pkg::cfg_t                 cfg,
    input  logic signed [15:0]            in_pedal_position,
    input  logic signed [15:0]            in_longitudinal_accel,
    input  logic [15:0]                   in_delta_time,
    output ets_pkg::dp_status_t           status,
    output logic [ets_pkg::TORQUE_W-1:0]  engine_torque,
    output logic [ets_pkg::TORQUE_W-1:0]  max_torque,
    output logic [ets_pkg::TORQUE_W-1:0]  limited_torque
);

    logic [ets_pkg::TBL_IDX_W-1:0] seg_idx;
    logic                          seg_hit;
    logic [ets_pkg::TBL_IDX_W-1:0] seg_reg;
    logic [ets_pkg::TBL_IDX_W-1:0] seg_nxt;
    logic                          hit_reg;

    logic [ets_pkg::PEDAL_W-1:0]   pedal_reg;
    logic [ets_pkg::DRATE_W-1:0]   drate_reg;
    logic [15:0]                   dt_reg;
    logic [ets_pkg::PEDAL_W-1:0]   pedal_clamp;
    logic [ets_pkg::DRATE_W-1:0]   drate_clamp;
    logic signed [16:0]            accel_off;

    logic [ets_pkg::FACTOR_W-1:0]  f_sat;
    logic [ets_pkg::FACTOR_W-1:0]  c_sat;

    logic [15:0]                   x1, x2, y1, y2;
    logic [15:0]                   dx_off;
    logic [15:0]                   dy_mag;
    logic [31:0]                   mag_reg;
    logic [15:0]                   den_reg;
    logic                          neg_reg;
    logic [19:0]                   derate_drop;
    logic [ets_pkg::GAIN_W-1:0]    gain_reg;

    logic [31:0]                   ped_num;
    logic [20:0]                   ped_scaled;
    logic [41:0]                   recip_reg;

    logic                          div_start;
    logic [ets_pkg::DIV_NUM_W-1:0] div_dividend;
    logic [ets_pkg::DIV_DEN_W-1:0] div_divisor;
    logic                          div_done;
    logic [ets_pkg::DIV_Q_W-1:0]   div_q;

    logic signed [17:0]            maxt_s;
    logic [ets_pkg::TORQUE_W-1:0]  maxt_v;
    logic [ets_pkg::TORQUE_W-1:0]  maxt_reg;
    logic [ets_pkg::TORQUE_W-1:0]  raw_reg;

    logic [34:0]                   lim_prod;
    logic [34:0]                   lim_sum;
    logic [16:0]                   lim_v;
    logic [ets_pkg::TORQUE_W-1:0]  lim_reg;

    logic [15:0]                   diff_mag;
    logic [24:0]                   dc_reg;
    logic                          dneg_reg;
    logic [40:0]                   m_reg;
    logic [40:0]                   m_sum;
    logic [16:0]                   step_q;
    logic signed [18:0]            filt_s;
    logic [ets_pkg::TORQUE_W-1:0]  filt_v;
    logic [ets_pkg::TORQUE_W-1:0]  filt_reg;

    logic [ets_pkg::TORQUE_W-1:0]  eng_out_reg;
    logic [ets_pkg::TORQUE_W-1:0]  max_out_reg;
    logic [ets_pkg::TORQUE_W-1:0]  lim_out_reg;

    always_comb begin
        seg_hit = 1'b0;
        seg_idx = '0;
        for (int i = 0; i < ets_pkg::CURVE_POINTS - 1; i++) begin
            if (!seg_hit && (ets_pkg::CURVE_X[i+1] > ets_pkg::CURVE_X[i])
                    && (cfg.engine_speed >= ets_pkg::CURVE_X[i])
                    && (cfg.engine_speed <= ets_pkg::CURVE_X[i+1])
                    && (cfg.engine_speed <=
                        ets_pkg::CURVE_X[ets_pkg::CURVE_POINTS-1])) begin
                seg_hit = 1'b1;
                seg_idx = ets_pkg::TBL_IDX_W'(i);
            end
        end
    end

    assign f_sat = (cfg.derate_factor > ets_pkg::FACTOR_ONE) ? ets_pkg::FACTOR_ONE
                                                             : cfg.derate_factor;
    assign c_sat = (cfg.filter_coefficient > ets_pkg::FACTOR_ONE) ? ets_pkg::FACTOR_ONE
                                                                  : cfg.filter_coefficient;

    always_comb begin
        if (in_pedal_position < 16'sd0) begin
            pedal_clamp = '0;
        end else if (in_pedal_position > $signed({1'b0, ets_pkg::PEDAL_FULL})) begin
            pedal_clamp = ets_pkg::PEDAL_FULL;
        end else begin
            pedal_clamp = in_pedal_position[ets_pkg::PEDAL_W-1:0];
        end
    end

    assign accel_off = 17'(in_longitudinal_accel) - 17'(ets_pkg::ACCEL_LO);

    always_comb begin
        if (in_longitudinal_accel < ets_pkg::ACCEL_LO) begin
            drate_clamp = '0;
        end else if (in_longitudinal_accel > ets_pkg::ACCEL_HI) begin
            drate_clamp = ets_pkg::DRATE_SPAN;
        end else begin
            drate_clamp = accel_off[ets_pkg::DRATE_W-1:0];
        end
    end

    assign seg_nxt = seg_reg + 1'b1;
    assign x1      = ets_pkg::CURVE_X[seg_reg];
    assign x2      = ets_pkg::CURVE_X[seg_nxt];
    assign y1      = ets_pkg::CURVE_Y[seg_reg];
    assign y2      = ets_pkg::CURVE_Y[seg_nxt];
    assign dx_off  = cfg.engine_speed - x1;
    assign dy_mag  = (y2 >= y1) ? (y2 - y1) : (y1 - y2);

    assign derate_drop = drate_reg * (ets_pkg::FACTOR_ONE - f_sat);

    // divide by 25600 as a shift by 10 and a reciprocal multiply for 25
    assign ped_num    = mag_reg + 32'd12800;
    assign ped_scaled = ped_num[30:10];

    assign div_start    = (cmd.op == ets_pkg::OP_DIV_SEG);
    assign div_dividend = mag_reg + {17'd0, den_reg[15:1]};
    assign div_divisor  = den_reg;

    ets_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    assign status.div_done = div_done;

    always_comb begin
        if (neg_reg) begin
            maxt_s = $signed({2'b00, y1}) - $signed({2'b00, div_q});
        end else begin
            maxt_s = $signed({2'b00, y1}) + $signed({2'b00, div_q});
        end
        if (!hit_reg || maxt_s < 18'sd0) begin
            maxt_v = '0;
        end else if (maxt_s > $signed({2'b00, ets_pkg::TORQUE_MAX})) begin
            maxt_v = ets_pkg::TORQUE_MAX;
        end else begin
            maxt_v = maxt_s[15:0];
        end
    end

    assign lim_prod = 35'(raw_reg) * 35'(gain_reg);
    assign lim_sum  = lim_prod + 35'd131072;
    assign lim_v    = lim_sum[34:18];

    assign diff_mag = (lim_reg >= filt_reg) ? (lim_reg - filt_reg) : (filt_reg - lim_reg);

    assign m_sum  = m_reg + 41'd8388608;
    assign step_q = m_sum[40:24];

    always_comb begin
        if (dneg_reg) begin
            filt_s = $signed({3'b000, filt_reg}) - $signed({2'b00, step_q});
        end else begin
            filt_s = $signed({3'b000, filt_reg}) + $signed({2'b00, step_q});
        end
        if (filt_s < 19'sd0) begin
            filt_v = '0;
        end else if (filt_s > $signed({3'b000, ets_pkg::TORQUE_MAX})) begin
            filt_v = ets_pkg::TORQUE_MAX;
        end else begin
            filt_v = filt_s[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filt_reg <= '0;
        end else if (cmd.op == ets_pkg::OP_FILT) begin
            filt_reg <= filt_v;
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            ets_pkg::OP_LOAD: begin
                seg_reg   <= seg_idx;
                hit_reg   <= seg_hit;
                pedal_reg <= pedal_clamp;
                drate_reg <= drate_clamp;
                dt_reg    <= in_delta_time;
            end
            ets_pkg::OP_SEG_MUL: begin
                mag_reg  <= 32'(dx_off) * 32'(dy_mag);
                den_reg  <= x2 - x1;
                neg_reg  <= (y2 < y1);
                gain_reg <= ets_pkg::GAIN_ONE - derate_drop[ets_pkg::GAIN_W-1:0];
            end
            ets_pkg::OP_MAXT: begin
                maxt_reg <= maxt_v;
            end
            ets_pkg::OP_PED_MUL: begin
                mag_reg <= 32'(maxt_reg) * 32'(pedal_reg);
            end
            ets_pkg::OP_DIV_PED: begin
                recip_reg <= 42'(ped_scaled) * 42'(ets_pkg::PED_RECIP);
            end
            ets_pkg::OP_RAW: begin
                raw_reg <= recip_reg[41:26];
            end
            ets_pkg::OP_LIM: begin
                lim_reg <= (lim_v > {1'b0, ets_pkg::TORQUE_MAX}) ? ets_pkg::TORQUE_MAX
                                                                 : lim_v[15:0];
            end
            ets_pkg::OP_DIFF: begin
                dc_reg   <= 25'(diff_mag) * 25'(c_sat);
                dneg_reg <= (lim_reg < filt_reg);
            end
            ets_pkg::OP_DT_MUL: begin
                m_reg <= 41'(dc_reg) * 41'(dt_reg);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            eng_out_reg <= filt_reg;
            max_out_reg <= maxt_reg;
            lim_out_reg <= lim_reg;
        end
    end

    assign engine_torque  = eng_out_reg;
    assign max_torque     = max_out_reg;
    assign limited_torque = lim_out_reg;

    a_filt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        filt_reg <= ets_pkg::TORQUE_MAX)
        else $error("filtered torque above range");

    a_lim_below_raw: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == ets_pkg::OP_LIM) |=> (lim_reg <= raw_reg))
        else $error("derated torque exceeds scaled torque");

    a_maxt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.op == ets_pkg::OP_MAXT) |=> (maxt_reg <= ets_pkg::TORQUE_MAX))
        else $error("curve torque above range");

endmodule

### rtl/ets_ctrl.sv
`timescale 1ns / 1ps

module ets_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    output logic                m_tvalid,
    input  logic                m_tready,
    input  ets_pkg::dp_status_t status,
    output ets_pkg::dp_cmd_t    cmd
);

    ets_pkg::state_t state_reg;
    ets_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ets_pkg::ST_IDLE:     if (s_tvalid) state_next = ets_pkg::ST_SEG_MUL;
            ets_pkg::ST_SEG_MUL:  state_next = ets_pkg::ST_DIV_SEG;
            ets_pkg::ST_DIV_SEG:  state_next = ets_pkg::ST_WAIT_SEG;
            ets_pkg::ST_WAIT_SEG: if (status.div_done) state_next = ets_pkg::ST_MAXT;
            ets_pkg::ST_MAXT:     state_next = ets_pkg::ST_PED_MUL;
            ets_pkg::ST_PED_MUL:  state_next = ets_pkg::ST_DIV_PED;
            ets_pkg::ST_DIV_PED:  state_next = ets_pkg::ST_RAW;
            ets_pkg::ST_RAW:      state_next = ets_pkg::ST_LIM;
            ets_pkg::ST_LIM:      state_next = ets_pkg::ST_DIFF;
            ets_pkg::ST_DIFF:     state_next = ets_pkg::ST_DT_MUL;
            ets_pkg::ST_DT_MUL:   state_next = ets_pkg::ST_FILT;
            ets_pkg::ST_FILT:     state_next = ets_pkg::ST_DONE;
            ets_pkg::ST_DONE:     if (out_free) state_next = ets_pkg::ST_IDLE;
            default:              state_next = ets_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        cmd.op       = ets_pkg::OP_NONE;
        cmd.out_load = 1'b0;
        s_tready     = 1'b0;
        case (state_reg)
            ets_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) cmd.op = ets_pkg::OP_LOAD;
            end
            ets_pkg::ST_SEG_MUL: cmd.op = ets_pkg::OP_SEG_MUL;
            ets_pkg::ST_DIV_SEG: cmd.op = ets_pkg::OP_DIV_SEG;
            ets_pkg::ST_MAXT:    cmd.op = ets_pkg::OP_MAXT;
            ets_pkg::ST_PED_MUL: cmd.op = ets_pkg::OP_PED_MUL;
            ets_pkg::ST_DIV_PED: cmd.op = ets_pkg::OP_DIV_PED;
            ets_pkg::ST_RAW:     cmd.op = ets_pkg::OP_RAW;
            ets_pkg::ST_LIM:     cmd.op = ets_pkg::OP_LIM;
            ets_pkg::ST_DIFF:    cmd.op = ets_pkg::OP_DIFF;
            ets_pkg::ST_DT_MUL:  cmd.op = ets_pkg::OP_DT_MUL;
            ets_pkg::ST_FILT:    cmd.op = ets_pkg::OP_FILT;
            ets_pkg::ST_DONE:    cmd.out_load = out_free;
            default: begin
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ets_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ets_pkg::ST_SEG_MUL))
        else $error("accepted request did not start");

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        status.div_done |-> (state_reg == ets_pkg::ST_WAIT_SEG))
        else $error("divider finished outside a wait state");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |=> (m_tvalid && state_reg == ets_pkg::ST_IDLE))
        else $error("loaded result not presented");

endmodule

### rtl/engine_torque_request_shaper_top.sv
`timescale 1ns / 1ps

// Channel   Dir  Width  Contents
// s_axis    in   48     tdata: pedal_position, longitudinal_accel, delta_time
// m_axis    out  48     tdata: engine_torque, max_torque, limited_torque
// apb       in   32     engine_speed @0x0, derate_factor @0x4, filter_coefficient @0x8
//
// Per request: a 16-step serial division for curve interpolation, a reciprocal multiply
// for pedal scaling, plus the sequencer steps; requests are accepted only in idle.
// Synchronous active-low reset clears the sequencer, output valid, filter state
// and loads the register defaults.
// A result held on m_axis does not block the next request; only the finish of
// that next request waits for the output register to drain.

module engine_torque_request_shaper_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // pedal_position, longitudinal_accel, delta_time
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // engine_torque, max_torque, limited_torque
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0] engine_speed_reg;
    logic [8:0]  derate_factor_reg;
    logic [8:0]  filter_coef_reg;
    logic        cfg_write;

    ets_pkg::cfg_t       cfg;
    ets_pkg::dp_cmd_t    cmd;
    ets_pkg::dp_status_t status;

    logic [15:0] engine_torque;
    logic [15:0] max_torque;
    logic [15:0] limited_torque;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            engine_speed_reg  <= ets_pkg::ENGINE_SPEED_RST;
            derate_factor_reg <= ets_pkg::DERATE_RST;
            filter_coef_reg   <= ets_pkg::FILTER_RST;
        end else if (cfg_write) begin
            case (paddr[3:2])
                ets_pkg::REG_ENGINE_SPEED:  engine_speed_reg  <= pwdata[15:0];
                ets_pkg::REG_DERATE_FACTOR: derate_factor_reg <= pwdata[8:0];
                ets_pkg::REG_FILTER_COEF:   filter_coef_reg   <= pwdata[8:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            ets_pkg::REG_ENGINE_SPEED:  prdata = {16'd0, engine_speed_reg};
            ets_pkg::REG_DERATE_FACTOR: prdata = {23'd0, derate_factor_reg};
            ets_pkg::REG_FILTER_COEF:   prdata = {23'd0, filter_coef_reg};
            default:                    prdata = 32'd0;
        endcase
    end

    assign cfg.engine_speed       = engine_speed_reg;
    assign cfg.derate_factor      = derate_factor_reg;
    assign cfg.filter_coefficient = filter_coef_reg;

    ets_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    ets_datapath u_datapath (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cmd                   (cmd),
        .cfg                   (cfg),
        .in_pedal_position     ($signed(s_tdata[15:0])),
        .in_longitudinal_accel ($signed(s_tdata[31:16])),
        .in_delta_time         (s_tdata[47:32]),
        .status                (status),
        .engine_torque         (engine_torque),
        .max_torque            (max_torque),
        .limited_torque        (limited_torque)
    );

    assign m_tdata = {limited_torque, max_torque, engine_torque};

endmodule

### verif/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int LONG_HOLD   = 400;
    localparam int SETTLE      = 60;
    localparam int PHASES      = 10;
    localparam int PHASE_ITEMS = 60;
    localparam int DIR_ROWS    = 17;
    localparam int PRINT_CAP   = 200;

    typedef struct packed {
        logic [15:0] limited;
        logic [15:0] maximum;
        logic [15:0] engine;
    } torque_res_t;

    typedef struct packed {
        logic [15:0] pedal;
        logic [15:0] accel;
        logic [15:0] dt;
        logic        typed;
        torque_res_t want;
    } tick_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;   // pedal_position, longitudinal_accel, delta_time
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;        // engine_torque, max_torque, limited_torque
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    engine_torque_request_shaper_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        aclk = 1'b1;
        #1;
        aclk = 1'b0;
        #1;
    end

    longint spd_pts [17] = '{
        0, 16085, 18766, 21446, 24127, 26808, 29489, 32170, 34851,
        37531, 40212, 42893, 45574, 48255, 50936, 53616, 56297
    };
    longint trq_pts [17] = '{
        0, 26560, 30080, 35840, 46400, 56800, 56800, 56800, 56800,
        56800, 55520, 52960, 49920, 46080, 42560, 26880, 0
    };

    tick_row_t dir_rows [DIR_ROWS] = '{
        '{16'd0,     16'd0,     16'd0,     1'b1, '{16'd0,     16'd56800, 16'd0}},
        '{16'd25600, 16'd0,     16'd0,     1'b1, '{16'd56800, 16'd56800, 16'd0}},
        '{16'h7FFF,  16'h8000,  16'd0,     1'b1, '{16'd56800, 16'd56800, 16'd0}},
        '{16'h8000,  16'h7FFF,  16'hFFFF,  1'b1, '{16'd0,     16'd56800, 16'd0}},
        '{16'd25600, 16'h7FFF,  16'd0,     1'b1, '{16'd28400, 16'd56800, 16'd0}},
        '{16'd25600, 16'd4505,  16'd0,     1'b1, '{16'd56800, 16'd56800, 16'd0}},
        '{16'd25600, 16'd4506,  16'd0,     1'b1, '{16'd56800, 16'd56800, 16'd0}},
        '{16'd25600, 16'd5530,  16'd0,     1'b1, '{16'd28400, 16'd56800, 16'd0}},
        '{16'd25600, 16'd5531,  16'd0,     1'b1, '{16'd28400, 16'd56800, 16'd0}},
        '{16'd12800, 16'd5018,  16'd0,     1'b0, '0},
        '{16'd25600, 16'd0,     16'hFFFF,  1'b1, '{16'd56800, 16'd56800, 16'd56799}},
        '{16'd0,     16'd0,     16'hFFFF,  1'b0, '0},
        '{16'd1,     16'hFFFF,  16'd1,     1'b0, '0},
        '{16'd25599, 16'd5529,  16'h8000,  1'b0, '0},
        '{16'h7FFF,  16'h8000,  16'hFFFF,  1'b0, '0},
        '{16'd256,   16'd4507,  16'd100,   1'b0, '0},
        '{16'h00FF,  16'h1000,  16'h8000,  1'b0, '0}
    };

    logic [15:0] cfg_speed  = ets_pkg::ENGINE_SPEED_RST;
    logic [8:0]  cfg_derate = ets_pkg::DERATE_RST;
    logic [8:0]  cfg_filter = ets_pkg::FILTER_RST;
    longint      filt_torque = 0;

    torque_res_t torque_q [$];
    int          err_cnt = 0;
    int          items_sent = 0;
    int          tx_idle_pct = 38;
    int          rx_idle_pct = 85;
    bit          burst = 1'b0;
    bit          long_hold = 1'b0;
    int          hold_cnt = 0;

    task automatic flag_mismatch(input string msg);
        if (err_cnt < PRINT_CAP)
            $display("mismatch at %0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    function automatic longint round_div(input longint num, input longint den);
        if (den <= 0) return 0;
        if (num >= 0) return (num + den / 2) / den;
        return -((-num + den / 2) / den);
    endfunction

    function automatic longint curve_at(input logic [15:0] speed);
        longint s;
        longint v;
        s = speed;
        if (s > spd_pts[16]) return 0;
        for (int i = 0; i < 16; i++) begin
            if (spd_pts[i+1] > spd_pts[i] && s >= spd_pts[i] && s <= spd_pts[i+1]) begin
                v = trq_pts[i] + round_div((s - spd_pts[i]) * (trq_pts[i+1] - trq_pts[i]),
                                           spd_pts[i+1] - spd_pts[i]);
                if (v < 0) v = 0;
                if (v > ets_pkg::TORQUE_MAX) v = ets_pkg::TORQUE_MAX;
                return v;
            end
        end
        return 0;
    endfunction

    function automatic torque_res_t shape_torque(input logic [15:0] pedal,
                                                 input logic [15:0] accel,
                                                 input logic [15:0] dt);
        longint ped;
        longint acc;
        longint f;
        longint c;
        longint maxt;
        longint raw;
        longint lim;
        longint gain;
        longint t;
        torque_res_t r;
        ped  = longint'($signed(pedal));
        acc  = longint'($signed(accel));
        f    = (cfg_derate > 9'd256) ? 256 : longint'(cfg_derate);
        c    = (cfg_filter > 9'd256) ? 256 : longint'(cfg_filter);
        maxt = curve_at(cfg_speed);
        if (ped < 0) ped = 0;
        if (ped > ets_pkg::PEDAL_FULL) ped = ets_pkg::PEDAL_FULL;
        raw = round_div(maxt * ped, ets_pkg::PEDAL_FULL);
        if (acc < ets_pkg::ACCEL_LO) begin
            lim = raw;
        end else if (acc > ets_pkg::ACCEL_HI) begin
            lim = (raw * f + 128) >>> 8;
        end else begin
            gain = 262144 - (acc - ets_pkg::ACCEL_LO) * (256 - f);
            lim = (raw * gain + 131072) >>> 18;
        end
        if (lim > ets_pkg::TORQUE_MAX) lim = ets_pkg::TORQUE_MAX;
        t = filt_torque + round_div((lim - filt_torque) * c * longint'(dt), longint'(1) << 24);
        if (t < 0) t = 0;
        if (t > ets_pkg::TORQUE_MAX) t = ets_pkg::TORQUE_MAX;
        filt_torque = t;
        r.engine  = t[15:0];
        r.maximum = maxt[15:0];
        r.limited = lim[15:0];
        return r;
    endfunction

    function automatic tick_row_t rand_row();
        tick_row_t r;
        r = '0;
        r.pedal = ($urandom_range(9) < 6) ? 16'($urandom_range(25600)) : 16'($urandom);
        r.accel = ($urandom_range(9) < 5) ? 16'($urandom_range(5700, 4300)) : 16'($urandom);
        r.dt    = ($urandom_range(9) < 3) ? 16'($urandom_range(2000)) : 16'($urandom);
        return r;
    endfunction

    task automatic send_tick(input tick_row_t row);
        torque_res_t p;
        if (items_sent < 210) begin
            tx_idle_pct = 38;
            rx_idle_pct = 85;
        end else if (items_sent < 420) begin
            tx_idle_pct = 85;
            rx_idle_pct = 38;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
        if (!burst) begin
            while ($urandom_range(99) < tx_idle_pct) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {row.dt, row.accel, row.pedal};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        p = shape_torque(row.pedal, row.accel, row.dt);
        torque_q.push_back(row.typed ? row.want : p);
        items_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (torque_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic reg_write(input ets_pkg::reg_idx_t idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            ets_pkg::REG_ENGINE_SPEED:  cfg_speed  = val[15:0];
            ets_pkg::REG_DERATE_FACTOR: cfg_derate = val[8:0];
            ets_pkg::REG_FILTER_COEF:   cfg_filter = val[8:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic reg_check(input ets_pkg::reg_idx_t idx, input logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        if (prdata !== want)
            flag_mismatch($sformatf("register %s read %0d, want %0d", idx.name(), prdata, want));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic check_regs();
        reg_check(ets_pkg::REG_ENGINE_SPEED, {16'd0, cfg_speed});
        reg_check(ets_pkg::REG_DERATE_FACTOR, {23'd0, cfg_derate});
        reg_check(ets_pkg::REG_FILTER_COEF, {23'd0, cfg_filter});
    endtask

    task automatic set_regs(input logic [15:0] speed, input logic [8:0] derate,
                            input logic [8:0] filter);
        reg_write(ets_pkg::REG_ENGINE_SPEED, {16'd0, speed});
        reg_write(ets_pkg::REG_DERATE_FACTOR, {23'd0, derate});
        reg_write(ets_pkg::REG_FILTER_COEF, {23'd0, filter});
        check_regs();
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            hold_cnt <= 0;
        end else if (long_hold && hold_cnt < LONG_HOLD) begin
            m_tready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
        end else begin
            if (!long_hold) hold_cnt <= 0;
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        torque_res_t got;
        torque_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (torque_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected result %h", m_tdata));
            end else begin
                want = torque_q.pop_front();
                if (got.engine !== want.engine)
                    flag_mismatch($sformatf("engine_torque %0d, want %0d",
                                            got.engine, want.engine));
                if (got.maximum !== want.maximum)
                    flag_mismatch($sformatf("max_torque %0d, want %0d",
                                            got.maximum, want.maximum));
                if (got.limited !== want.limited)
                    flag_mismatch($sformatf("limited_torque %0d, want %0d",
                                            got.limited, want.limited));
            end
        end
    end

    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        logic [15:0] speed;
        logic [8:0]  derate;
        logic [8:0]  filter;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset defaults
        check_regs();

        set_regs(16'd26808, 9'd128, 9'd256);
        for (int i = 0; i < DIR_ROWS; i++) send_tick(dir_rows[i]);
        drain();

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin speed = 16'd16077; derate = 9'd128; filter = 9'd128; end
                1: begin speed = 16'd0;     derate = 9'd0;   filter = 9'd256; end
                2: begin speed = 16'hFFFF;  derate = 9'd256; filter = 9'd0;   end
                3: begin speed = 16'd56297; derate = 9'd511; filter = 9'd511; end
                4: begin speed = 16'd26808; derate = 9'd0;   filter = 9'd256; end
                5: begin speed = 16'd56296; derate = 9'd300; filter = 9'd300; end
                6: begin speed = 16'd16085; derate = 9'd64;  filter = 9'd200; end
                default: begin
                    speed  = 16'($urandom_range(56297));
                    derate = 9'($urandom_range(511));
                    filter = 9'($urandom_range(511));
                end
            endcase
            set_regs(speed, derate, filter);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 4 && k == 20) begin
                    // hold the receiver while requests keep coming
                    long_hold <= 1'b1;
                    burst = 1'b1;
                end
                if (p == 4 && k == 32) begin
                    long_hold <= 1'b0;
                    burst = 1'b0;
                end
                send_tick(rand_row());
            end
            drain();
        end

        if (err_cnt == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
